@@ hw/rtl/lzdec_pkg.sv @@
package lzdec_pkg;

	localparam int unsigned WindowSize = 4096;

	localparam logic [7:0] TypeLz10 = 8'h10;
	localparam logic [7:0] TypeLz11 = 8'h11;
	localparam logic [16:0] Lz11LongBase = 17'h00111;
	localparam logic [16:0] Lz11MidBase = 17'h00011;
	localparam logic [16:0] Lz10Base = 17'd3;

	typedef enum logic [2:0] {
		PH_TYPE  = 3'd0,
		PH_SIZE0 = 3'd1,
		PH_SIZE1 = 3'd2,
		PH_SIZE2 = 3'd3,
		PH_FLAG  = 3'd4,
		PH_ITEM  = 3'd5,
		PH_DRAIN = 3'd6
	} phase_t;

	typedef enum logic [1:0] {
		FMT_NONE = 2'd0,
		FMT_LZ10 = 2'd1,
		FMT_LZ11 = 2'd2
	} fmt_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_BADTYPE = 2'd1,
		ST_BADREF  = 2'd2
	} status_t;

	typedef struct packed {
		logic [7:0] data;
		logic       owed;
		logic       done;
		logic [1:0] status;
	} res_t;

endpackage

@@ hw/rtl/lz10_lz11_stream_decompressor_core.sv @@
// LZ10/LZ11 stream decompressor.
// Input channel (in_valid/in_ready): each beat is a compressed byte
// (operation 0, in_last on the final byte) or a continue request
// (operation 1) that asks for the next owed copy or pad byte.
// Output channel (out_valid/out_ready): at most one decompressed byte per
// input beat, with more_owed, stream_done and status.
// A beat is taken every cycle while in_ready is high; a result is registered
// in the window-read stage and then in the output buffer.
// Window reads and writes go through one 4096x8 RAM; a copy at distance one
// is forwarded from the byte written in the cycle before.
// A three-entry output buffer absorbs receiver stalls; in_ready drops only
// while that buffer plus the byte in flight would be full.
// Reset returns the parser to expecting a type byte; window contents are
// undefined until written, and no clearing pass is run.
module lz10_lz11_stream_decompressor_core
	import lzdec_pkg::*;
#(
	parameter int unsigned WINDOW_SIZE = WindowSize
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       operation,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       more_owed,
	output logic       stream_done,
	output logic [1:0] status
);

	localparam int unsigned AW = $clog2(WINDOW_SIZE);

	phase_t      ph_q, n_ph;
	fmt_t        fmt_q, n_fmt;
	logic [7:0]  fb_q, n_fb;
	logic [2:0]  fi_q, n_fi;
	logic [23:0] tok_q, n_tok;
	logic [1:0]  tokn_q, n_tokn;
	logic [16:0] crem_q, n_crem;
	logic [AW:0] cdist_q, n_cdist;
	logic        ended_q, n_ended;
	logic [AW-1:0] wi_q, n_wi;
	logic [23:0] pc_q, n_pc;
	logic [23:0] tsz_q, n_tsz;

	logic        have, err, from_mem;
	logic [7:0]  val;
	status_t     st;
	logic [AW-1:0] rd_addr;
	logic        owed, done;

	logic        accept;
	logic        body;
	logic [7:0]  first;
	logic [2:0]  need;
	logic [16:0] len;
	logic [AW:0] bdist;
	logic [23:0] room;
	logic [16:0] room_c;

	assign accept = in_valid && in_ready;
	assign body = (ph_q == PH_FLAG) || (ph_q == PH_ITEM);
	assign room = tsz_q - pc_q;
	assign room_c = (room > 24'(17'h1FFFF)) ? 17'h1FFFF : room[16:0];

	always_comb begin
		case (tokn_q)
			2'd1: first = tok_q[7:0];
			2'd2: first = tok_q[15:8];
			2'd3: first = tok_q[23:16];
			default: first = in_byte;
		endcase
		need = 3'd2;
		if (fmt_q == FMT_LZ11) begin
			if (first[7:4] == 4'h1) begin
				need = 3'd4;
			end else if (first[7:4] == 4'h0) begin
				need = 3'd3;
			end
		end
		bdist = (AW+1)'({tok_q[3:0], in_byte}) + (AW+1)'(1);
		if (fmt_q == FMT_LZ10) begin
			len = Lz10Base + 17'(tok_q[7:4]);
		end else if (need == 3'd4) begin
			len = Lz11LongBase + 17'({tok_q[19:16], 12'd0})
				+ 17'({tok_q[15:8], 4'd0}) + 17'(tok_q[7:4]);
		end else if (need == 3'd3) begin
			len = Lz11MidBase + 17'({tok_q[11:8], 4'd0}) + 17'(tok_q[7:4]);
		end else begin
			len = 17'd1 + 17'(tok_q[7:4]);
		end
	end

	always_comb begin
		n_ph = ph_q;
		n_fmt = fmt_q;
		n_fb = fb_q;
		n_fi = fi_q;
		n_tok = tok_q;
		n_tokn = tokn_q;
		n_crem = crem_q;
		n_cdist = cdist_q;
		n_ended = ended_q;
		n_wi = wi_q;
		n_pc = pc_q;
		n_tsz = tsz_q;
		have = 1'b0;
		err = 1'b0;
		from_mem = 1'b0;
		val = 8'd0;
		st = ST_OK;
		rd_addr = wi_q - cdist_q[AW-1:0];
		owed = 1'b0;
		done = 1'b0;

		if (operation) begin
			if (body) begin
				if (crem_q != 17'd0) begin
					from_mem = 1'b1;
					have = 1'b1;
					n_crem = crem_q - 17'd1;
				end else if (ended_q && (pc_q < tsz_q)) begin
					have = 1'b1;
				end
			end
		end else begin
			case (ph_q)
				PH_TYPE: begin
					n_pc = '0;
					n_tsz = '0;
					if (in_byte == TypeLz10) begin
						n_fmt = FMT_LZ10;
					end else if (in_byte == TypeLz11) begin
						n_fmt = FMT_LZ11;
					end else begin
						err = 1'b1;
						st = ST_BADTYPE;
					end
					if (!err) begin
						n_ph = in_last ? PH_TYPE : PH_SIZE0;
						if (in_last) begin
							n_fmt = FMT_NONE;
						end
					end
				end
				PH_SIZE0, PH_SIZE1: begin
					if (ph_q == PH_SIZE0) begin
						n_tsz[7:0] = in_byte;
						n_ph = PH_SIZE1;
					end else begin
						n_tsz[15:8] = in_byte;
						n_ph = PH_SIZE2;
					end
					if (in_last) begin
						n_ph = PH_TYPE;
						n_fmt = FMT_NONE;
					end
				end
				PH_SIZE2: begin
					n_tsz[23:16] = in_byte;
					n_ph = PH_FLAG;
					n_ended = in_last;
					if ({in_byte, tsz_q[15:0]} == 24'd0) begin
						n_ph = in_last ? PH_TYPE : PH_DRAIN;
						n_ended = 1'b0;
						n_fmt = FMT_NONE;
					end else if (in_last) begin
						have = 1'b1;
					end
				end
				PH_DRAIN: begin
					if (in_last) begin
						n_ph = PH_TYPE;
					end
				end
				PH_FLAG, PH_ITEM: begin
					if (ended_q) begin
						n_ended = ended_q;
					end else if (crem_q != 17'd0) begin
						n_ended = in_last;
					end else begin
						if (ph_q == PH_FLAG) begin
							n_fb = in_byte;
							n_fi = 3'd0;
							n_ph = PH_ITEM;
						end else if (!fb_q[3'd7 - fi_q]) begin
							have = 1'b1;
							val = in_byte;
							n_fi = fi_q + 3'd1;
							if (fi_q == 3'd7) begin
								n_ph = PH_FLAG;
							end
						end else if ({1'b0, tokn_q} + 3'd1 < need) begin
							n_tok = {tok_q[15:0], in_byte};
							n_tokn = tokn_q + 2'd1;
						end else begin
							n_tok = '0;
							n_tokn = '0;
							if (24'(bdist) > pc_q) begin
								err = 1'b1;
								st = ST_BADREF;
							end else begin
								n_crem = ((len < room_c) ? len : room_c) - 17'd1;
								n_cdist = bdist;
								rd_addr = wi_q - bdist[AW-1:0];
								from_mem = 1'b1;
								have = 1'b1;
								n_fi = fi_q + 3'd1;
								if (fi_q == 3'd7) begin
									n_ph = PH_FLAG;
								end
							end
						end
						if (in_last && !err) begin
							n_ended = 1'b1;
							n_tok = '0;
							n_tokn = '0;
							if (!have && (n_crem == 17'd0) && (pc_q < tsz_q)) begin
								have = 1'b1;
								val = 8'd0;
							end
						end
					end
				end
				default: begin
					n_ph = PH_TYPE;
					n_fmt = FMT_NONE;
					n_fb = '0;
					n_fi = '0;
					n_tok = '0;
					n_tokn = '0;
					n_crem = '0;
					n_cdist = '0;
				end
			endcase
		end

		if (err) begin
			have = 1'b1;
			val = 8'd0;
			from_mem = 1'b0;
			done = 1'b1;
			n_ph = in_last ? PH_TYPE : PH_DRAIN;
			n_ended = 1'b0;
		end else if (have) begin
			n_wi = wi_q + AW'(1);
			n_pc = pc_q + 24'd1;
			done = (n_pc >= n_tsz);
			owed = !done && ((n_crem != 17'd0) || n_ended);
			if (done) begin
				n_ph = n_ended ? PH_TYPE : PH_DRAIN;
				n_ended = 1'b0;
			end
		end
		if (err || done) begin
			n_fmt = FMT_NONE;
			n_fb = '0;
			n_fi = '0;
			n_tok = '0;
			n_tokn = '0;
			n_crem = '0;
			n_cdist = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= PH_TYPE;
			fmt_q <= FMT_NONE;
			fb_q <= '0;
			fi_q <= '0;
			tok_q <= '0;
			tokn_q <= '0;
			crem_q <= '0;
			cdist_q <= '0;
			ended_q <= 1'b0;
			wi_q <= '0;
			pc_q <= '0;
			tsz_q <= '0;
		end else if (accept) begin
			ph_q <= n_ph;
			fmt_q <= n_fmt;
			fb_q <= n_fb;
			fi_q <= n_fi;
			tok_q <= n_tok;
			tokn_q <= n_tokn;
			crem_q <= n_crem;
			cdist_q <= n_cdist;
			ended_q <= n_ended;
			wi_q <= n_wi;
			pc_q <= n_pc;
			tsz_q <= n_tsz;
		end
	end

	logic          v_s1, mem_s1, wr_s1, owed_s1, done_s1;
	logic [7:0]    val_s1;
	logic [1:0]    st_s1;
	logic [AW-1:0] ra_s1, wa_s1;
	logic          fwd_v_q;
	logic [AW-1:0] fwd_a_q;
	logic [7:0]    fwd_d_q;
	logic [7:0]    rdata, b_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			fwd_v_q <= 1'b0;
		end else begin
			v_s1 <= accept && have;
			fwd_v_q <= v_s1 && wr_s1;
		end
	end

	always_ff @(posedge clk) begin
		mem_s1 <= from_mem;
		wr_s1 <= !err;
		owed_s1 <= owed;
		done_s1 <= done;
		val_s1 <= val;
		st_s1 <= st;
		ra_s1 <= rd_addr;
		wa_s1 <= wi_q;
		fwd_a_q <= wa_s1;
		fwd_d_q <= b_s1;
	end

	assign b_s1 = !mem_s1 ? val_s1 :
		((fwd_v_q && (fwd_a_q == ra_s1)) ? fwd_d_q : rdata);

	lzdec_ram #(
		.Width(8),
		.Depth(WINDOW_SIZE)
	) u_window (
		.clk  (clk),
		.we   (v_s1 && wr_s1),
		.waddr(wa_s1),
		.wdata(b_s1),
		.re   (accept),
		.raddr(rd_addr),
		.rdata(rdata)
	);

	res_t       fifo_q [3];
	logic [1:0] head_q, tail_q, cnt_q;
	logic       pop;
	res_t       push_d;

	assign pop = out_valid && out_ready;
	assign out_valid = (cnt_q != 2'd0);
	assign in_ready = ({1'b0, cnt_q} + {2'b0, v_s1}) <= 3'd2;
	assign push_d = '{data: b_s1, owed: owed_s1, done: done_s1, status: st_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			cnt_q <= '0;
		end else begin
			if (v_s1) begin
				tail_q <= (tail_q == 2'd2) ? 2'd0 : tail_q + 2'd1;
			end
			if (pop) begin
				head_q <= (head_q == 2'd2) ? 2'd0 : head_q + 2'd1;
			end
			cnt_q <= cnt_q + {1'b0, v_s1} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			fifo_q[tail_q] <= push_d;
		end
	end

	assign out_byte = fifo_q[head_q].data;
	assign more_owed = fifo_q[head_q].owed;
	assign stream_done = fifo_q[head_q].done;
	assign status = fifo_q[head_q].status;

endmodule

@@ hw/rtl/lzdec_ram.sv @@
module lzdec_ram #(
	parameter int unsigned Width = 8,
	parameter int unsigned Depth = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);

	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ bench/lz10_lz11_stream_decompressor_core_test.sv @@
module lz10_lz11_stream_decompressor_core_test
	import lzdec_pkg::*;
();

	localparam int IDLE_LIMIT = 4000;
	localparam int HOLD_CYCLES = 300;
	localparam int RANDOM_BYTES = 700;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic operation = 1'b0;
	logic [7:0] in_byte = 8'h00;
	logic in_last = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [7:0] out_byte;
	logic more_owed;
	logic stream_done;
	logic [1:0] status;

	lz10_lz11_stream_decompressor_core DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.operation(operation), .in_byte(in_byte), .in_last(in_last),
		.out_valid(out_valid), .out_ready(out_ready),
		.out_byte(out_byte), .more_owed(more_owed),
		.stream_done(stream_done), .status(status)
	);

	always #4 clk = ~clk;

	// decoder shadow state
	logic [7:0] hist [WindowSize];
	logic [11:0] wr_idx = '0;
	logic [23:0] produced = '0;
	logic [23:0] target = '0;
	fmt_t fmt = FMT_NONE;
	phase_t phase = PH_TYPE;
	logic [7:0] flags = '0;
	int flag_pos = 0;
	logic [23:0] tok = '0;
	int tok_cnt = 0;
	int copy_left = 0;
	int copy_dist = 0;
	bit ended = 0;

	res_t want_q [$];
	int errs = 0;
	int burst_left = 0;
	int data_sent = 0;
	bit hold_go = 0;
	bit hold_done = 0;
	int hold_cnt = 0;
	int rx_mode = 0;
	int rx_tick = 0;
	int idle = 0;

	function void clear_stream();
		fmt = FMT_NONE;
		flags = '0;
		flag_pos = 0;
		tok = '0;
		tok_cnt = 0;
		copy_left = 0;
		copy_dist = 0;
	endfunction

	function void close_stream();
		phase = ended ? PH_TYPE : PH_DRAIN;
		ended = 0;
		clear_stream();
	endfunction

	function void emit(logic [7:0] v);
		hist[wr_idx] = v;
		wr_idx = wr_idx + 12'd1;
		produced = produced + 24'd1;
	endfunction

	function logic [7:0] copy_one();
		logic [7:0] v;
		v = hist[wr_idx - copy_dist[11:0]];
		copy_left--;
		emit(v);
		return v;
	endfunction

	function res_t ok_byte(logic [7:0] v);
		res_t r;
		bit dn;
		dn = produced >= target;
		r.data = v;
		r.owed = !dn && (copy_left > 0 || ended);
		r.done = dn;
		r.status = ST_OK;
		if (dn) close_stream();
		return r;
	endfunction

	function res_t err_byte(status_t code, bit lst);
		res_t r;
		r.data = 8'h00;
		r.owed = 1'b0;
		r.done = 1'b1;
		r.status = code;
		ended = lst;
		close_stream();
		return r;
	endfunction

	function void next_flag();
		flag_pos++;
		if (flag_pos >= 8) begin
			flag_pos = 0;
			phase = PH_FLAG;
		end
	endfunction

	function bit decode_step(bit op, logic [7:0] b, bit lst, output res_t r);
		bit body;
		bit have;
		logic [7:0] res;
		logic [7:0] first;
		logic [7:0] prev;
		logic [7:0] b2;
		logic [7:0] b3;
		int need;
		int back_dist;
		int len;
		int room;
		body = (phase == PH_FLAG || phase == PH_ITEM);
		have = 0;
		res = 8'h00;
		r = '0;
		if (op) begin
			if (!body) return 0;
			if (copy_left > 0) begin
				r = ok_byte(copy_one());
				return 1;
			end
			if (ended && produced < target) begin
				emit(8'h00);
				r = ok_byte(8'h00);
				return 1;
			end
			return 0;
		end
		case (phase)
			PH_TYPE: begin
				produced = '0;
				target = '0;
				if (b == TypeLz10) fmt = FMT_LZ10;
				else if (b == TypeLz11) fmt = FMT_LZ11;
				else begin
					r = err_byte(ST_BADTYPE, lst);
					return 1;
				end
				phase = lst ? PH_TYPE : PH_SIZE0;
				if (lst) clear_stream();
				return 0;
			end
			PH_SIZE0, PH_SIZE1: begin
				if (phase == PH_SIZE0) begin
					target[7:0] = b;
					phase = PH_SIZE1;
				end else begin
					target[15:8] = b;
					phase = PH_SIZE2;
				end
				if (lst) begin
					phase = PH_TYPE;
					clear_stream();
				end
				return 0;
			end
			PH_SIZE2: begin
				target[23:16] = b;
				phase = PH_FLAG;
				ended = lst;
				if (target == 0) begin
					close_stream();
					return 0;
				end
				if (lst) begin
					emit(8'h00);
					r = ok_byte(8'h00);
					return 1;
				end
				return 0;
			end
			PH_DRAIN: begin
				if (lst) phase = PH_TYPE;
				return 0;
			end
			default: ;
		endcase
		if (ended) return 0;
		if (copy_left > 0) begin
			ended = lst;
			return 0;
		end
		if (phase == PH_FLAG) begin
			flags = b;
			flag_pos = 0;
			phase = PH_ITEM;
		end else if (flags[7 - flag_pos] == 1'b0) begin
			emit(b);
			res = b;
			have = 1;
			next_flag();
		end else begin
			need = 2;
			first = (tok_cnt == 0) ? b : tok[8 * (tok_cnt - 1) +: 8];
			if (fmt == FMT_LZ11) begin
				if (first[7:4] == 4'h1) need = 4;
				else if (first[7:4] == 4'h0) need = 3;
			end
			if (tok_cnt + 1 < need) begin
				tok = {tok[15:0], b};
				tok_cnt++;
			end else begin
				prev = tok[7:0];
				b2 = tok[15:8];
				b3 = tok[23:16];
				back_dist = 1 + (int'(prev[3:0]) << 8) + int'(b);
				if (fmt == FMT_LZ10) len = 3 + int'(prev[7:4]);
				else if (need == 4)
					len = 'h111 + (int'(b3[3:0]) << 12) + (int'(b2) << 4) + int'(prev[7:4]);
				else if (need == 3) len = 'h11 + (int'(b2[3:0]) << 4) + int'(prev[7:4]);
				else len = 1 + int'(prev[7:4]);
				tok = '0;
				tok_cnt = 0;
				if (back_dist > int'(produced)) begin
					r = err_byte(ST_BADREF, lst);
					return 1;
				end
				room = int'(target - produced);
				copy_left = (len < room) ? len : room;
				copy_dist = back_dist;
				next_flag();
				res = copy_one();
				have = 1;
			end
		end
		if (lst) begin
			ended = 1;
			tok = '0;
			tok_cnt = 0;
			if (!have && copy_left == 0 && produced < target) begin
				emit(8'h00);
				res = 8'h00;
				have = 1;
			end
		end
		if (have) begin
			r = ok_byte(res);
			return 1;
		end
		return 0;
	endfunction

	task automatic send(bit op, logic [7:0] b, bit lst, bit typed = 0, res_t fixed = '0);
		res_t r;
		if (decode_step(op, b, lst, r)) want_q.insert(want_q.size(), typed ? fixed : r);
		data_sent++;
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 150)
				: $urandom_range(1, 25);
		end
		burst_left--;
		in_valid <= 1'b1;
		operation <= op;
		in_byte <= b;
		in_last <= lst;
		do @(posedge clk); while (!in_ready);
	endtask

	function bit rare_last();
		return $urandom_range(0, 59) == 0;
	endfunction

	task automatic send_token();
		int back_dist;
		int n;
		logic [11:0] d1;
		logic [15:0] y;
		if (produced == 0 || $urandom_range(0, 32) == 0)
			back_dist = (produced >= 4096) ? 4096 : $urandom_range(int'(produced) + 1, 4096);
		else
			back_dist = $urandom_range(1, (produced > 4096) ? 4096 : int'(produced));
		d1 = 12'(back_dist - 1);
		n = $urandom_range(0, 15);
		if (fmt == FMT_LZ10 || n >= 2) begin
			send(0, {(fmt == FMT_LZ10) ? 4'($urandom) : 4'(n), d1[11:8]}, rare_last());
		end else if (n == 0) begin
			y = 16'($urandom);
			send(0, {4'h0, y[7:4]}, rare_last());
			send(0, {y[3:0], d1[11:8]}, rare_last());
		end else begin
			y = 16'($urandom);
			send(0, {4'h1, y[15:12]}, rare_last());
			send(0, y[11:4], rare_last());
			send(0, {y[3:0], d1[11:8]}, rare_last());
		end
		send(0, d1[7:0], rare_last());
	endtask

	task automatic run_stream();
		int pick;
		logic [23:0] sz;
		logic [7:0] fb;
		if ($urandom_range(0, 19) == 0) begin
			send(0, 8'($urandom), 0);
			repeat ($urandom_range(0, 3)) send(0, 8'($urandom), 0);
			send(0, 8'($urandom), 1);
			return;
		end
		pick = $urandom_range(0, 29);
		if (pick == 0) sz = '0;
		else if (pick == 1) sz = 24'($urandom_range(256, 400));
		else sz = 24'($urandom_range(1, 64));
		send(0, $urandom_range(0, 1) ? TypeLz11 : TypeLz10, 0);
		if ($urandom_range(0, 24) == 0) begin
			send(0, sz[7:0], 1);
			return;
		end
		send(0, sz[7:0], 0);
		send(0, sz[15:8], 0);
		send(0, sz[23:16], $urandom_range(0, 19) == 0);
		while (phase == PH_FLAG || phase == PH_ITEM) begin
			if (copy_left > 0 || ended) begin
				send(1, 8'($urandom), 0);
				if ($urandom_range(0, 9) == 0) send(0, 8'($urandom), $urandom_range(0, 7) == 0);
			end else if ($urandom_range(0, 29) == 0) begin
				send(1, 8'($urandom), 0);
			end else if (phase == PH_FLAG) begin
				fb = 8'($urandom);
				if (produced == 0 && $urandom_range(0, 9) != 0) fb[7] = 1'b0;
				send(0, fb, rare_last());
			end else if (flags[7 - flag_pos] == 1'b0) begin
				send(0, 8'($urandom), rare_last());
			end else begin
				send_token();
			end
		end
		if (phase == PH_DRAIN) begin
			repeat ($urandom_range(0, 3)) send(0, 8'($urandom), 0);
			send(0, 8'($urandom), 1);
		end
	endtask

	typedef struct {
		bit op;
		logic [7:0] b;
		bit lst;
		bit typed;
		res_t r;
	} row_t;

	row_t dir [27] = '{
		'{1, 8'h00, 0, 0, '0},
		'{0, 8'h00, 0, 1, {8'h00, 1'b0, 1'b1, ST_BADTYPE}},
		'{0, 8'hFF, 1, 0, '0},
		'{0, TypeLz10, 0, 0, '0},
		'{0, 8'h03, 0, 0, '0},
		'{0, 8'h00, 0, 0, '0},
		'{0, 8'h00, 0, 0, '0},
		'{0, 8'h00, 0, 0, '0},
		'{0, 8'hFF, 0, 1, {8'hFF, 1'b0, 1'b0, ST_OK}},
		'{0, 8'h00, 0, 1, {8'h00, 1'b0, 1'b0, ST_OK}},
		'{0, 8'h80, 0, 1, {8'h80, 1'b0, 1'b1, ST_OK}},
		'{0, 8'h55, 1, 0, '0},
		'{0, TypeLz10, 0, 0, '0},
		'{0, 8'h01, 0, 0, '0},
		'{0, 8'h00, 0, 0, '0},
		'{0, 8'h00, 0, 0, '0},
		'{0, 8'h80, 0, 0, '0},
		'{0, 8'hF0, 0, 0, '0},
		'{0, 8'h00, 0, 1, {8'h00, 1'b0, 1'b1, ST_BADREF}},
		'{0, 8'hAA, 1, 0, '0},
		'{0, TypeLz11, 0, 0, '0},
		'{0, 8'h02, 0, 0, '0},
		'{0, 8'h00, 0, 0, '0},
		'{0, 8'h00, 1, 1, {8'h00, 1'b1, 1'b0, ST_OK}},
		'{1, 8'h00, 0, 1, {8'h00, 1'b0, 1'b1, ST_OK}},
		'{0, TypeLz11, 0, 0, '0},
		'{0, 8'h00, 1, 0, '0}
	};

	always @(posedge clk) begin
		if (hold_cnt != 0) begin
			hold_cnt <= hold_cnt - 1;
			out_ready <= 1'b0;
		end else if (hold_go && !hold_done) begin
			hold_cnt <= HOLD_CYCLES;
			hold_done <= 1'b1;
			out_ready <= 1'b0;
		end else begin
			rx_tick <= rx_tick + 1;
			if (rx_tick % 64 == 0) rx_mode <= $urandom_range(0, 2);
			case (rx_mode)
				0: out_ready <= 1'b1;
				1: out_ready <= $urandom_range(0, 9) >= 3;
				default: out_ready <= $urandom_range(0, 9) >= 7;
			endcase
		end
	end

	always @(posedge clk) begin
		res_t w;
		if (out_valid && out_ready) begin
			if (want_q.size() == 0) begin
				$error("unexpected result: out_byte %h status %0d", out_byte, status);
				errs++;
			end else begin
				w = want_q.pop_front();
				if (out_byte !== w.data) begin
					$error("out_byte: expected %h, got %h", w.data, out_byte);
					errs++;
				end
				if (more_owed !== w.owed) begin
					$error("more_owed: expected %b, got %b", w.owed, more_owed);
					errs++;
				end
				if (stream_done !== w.done) begin
					$error("stream_done: expected %b, got %b", w.done, stream_done);
					errs++;
				end
				if (status !== w.status) begin
					$error("status: expected %0d, got %0d", w.status, status);
					errs++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) idle <= 0;
		else idle <= idle + 1;
		if (idle >= IDLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		int streams;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (dir[i]) send(dir[i].op, dir[i].b, dir[i].lst, dir[i].typed, dir[i].r);
		data_sent = 0;
		streams = 0;
		while (data_sent < RANDOM_BYTES) begin
			if (streams == 3) hold_go = 1;
			if (streams % 8 == 7) begin
				in_valid <= 1'b0;
				burst_left = 0;
				wait (want_q.size() == 0);
				@(posedge clk);
			end
			run_stream();
			streams++;
		end
		in_valid <= 1'b0;
		wait (want_q.size() == 0);
		repeat (20) @(posedge clk);
		if (errs == 0 && want_q.size() == 0) $display("[ OK ] regression clean");
		else $display("[FAIL] regression broken");
		$finish;
	end

endmodule
